### hdl/srv_pkg.sv
package srv_pkg;

	// Reference rate of the classic tuning table.
	localparam int REF_RATE = 44100;
	localparam int STEREO_SPREAD = 23;

	localparam int COMB_TUNE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_TUNE [4] = '{556, 441, 341, 225};

	// Operand and accumulator widths of the shared multiply-accumulate unit.
	localparam int OPA_W = 33;
	localparam int OPB_W = 18;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W = 52;
	localparam int RND_W = ACC_W - 16;

	// Q16 coefficients.
	localparam logic signed [OPB_W-1:0] Q_FEED = 18'sd1311;
	localparam logic signed [OPB_W-1:0] Q_ROOM = 18'sd51118;
	localparam logic signed [OPB_W-1:0] Q_DAMP = 18'sd18350;
	localparam logic signed [OPB_W-1:0] Q_UNDAMP = 18'sd47186;
	localparam logic signed [OPB_W-1:0] Q_APFB = 18'sd32768;
	localparam logic signed [OPB_W-1:0] Q_WET = 18'sd22938;
	localparam logic [16:0] MIX_FULL = 17'd65536;
	localparam logic [16:0] MIX_BYPASS = 17'd6;

	localparam int PADDR_W = 1;
	localparam logic [PADDR_W-1:0] REG_WET_MIX = 1'b0;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FEED,
		ST_FEED2,
		ST_C_RD,
		ST_C_M1,
		ST_C_M2,
		ST_C_F,
		ST_C_M3,
		ST_C_W,
		ST_A_RD,
		ST_A_M,
		ST_A_W,
		ST_WET,
		ST_WET2,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

	// Tuning length scaled to the build rate, at least one, plus one, capped at the depth.
	function automatic int line_len(int base, int sr, int depth);
		int n;
		n = (base * sr + REF_RATE / 2) / REF_RATE;
		if (n < 1) begin
			n = 1;
		end
		n = n + 1;
		if (n > depth) begin
			n = depth;
		end
		return n;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

### hdl/srv_mac.sv
module srv_mac (
	input  logic                                   clk,
	input  srv_pkg::mac_ctl_t                      ctl,
	input  logic signed [srv_pkg::OPA_W-1:0]       a,
	input  logic signed [srv_pkg::OPB_W-1:0]       b,
	output logic signed [srv_pkg::RND_W-1:0]       rnd
);

	logic signed [srv_pkg::PROD_W-1:0] prod;
	logic signed [srv_pkg::ACC_W-1:0]  acc_q;
	logic signed [srv_pkg::ACC_W-1:0]  acc_rnd;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? '0 : acc_q)
				+ {{(srv_pkg::ACC_W - srv_pkg::PROD_W){prod[srv_pkg::PROD_W-1]}}, prod};
		end
	end

	// Round half up, then floor by 2^16.
	assign acc_rnd = acc_q + srv_pkg::ACC_W'(32768);
	assign rnd = acc_rnd[srv_pkg::ACC_W-1:16];

endmodule

### hdl/srv_ram.sv
module srv_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hdl/stereo_comb_allpass_reverb_top.sv
// Bypass skips the comb, allpass, wet and mix steps: the accepted word goes straight to the result register.
// Otherwise each channel, left then right, runs every comb step, every allpass step and the wet and mix steps.
// Every step shares one multiply-accumulate unit and a single port pair on each delay memory, so the
// sequencer takes one item at a time and returns to idle before it takes the next; a result register
// that is still full holds the sequencer in the done state.
// Reset: arst_n clears all control state, then a clearing pass zeroes every word of both delay
// memories before the first input is accepted.
module stereo_comb_allpass_reverb_top #(
	parameter int AUDIO_RATE = 48000,
	parameter int COMB_COUNT = 4,
	parameter int ALLPASS_COUNT = 2,
	parameter int SAMPLE_WIDTH = 24,
	parameter int COMB_LINE_DEPTH = 2048,
	parameter int ALLPASS_LINE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input word: tdata holds left_in then right_in, from the lowest bit up, zero padded.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
	// Result word: tdata holds left_out then right_out, from the lowest bit up, zero padded.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [srv_pkg::PADDR_W-1:0]           paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	localparam int DATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
	localparam int NCOMB = 2*COMB_COUNT;
	localparam int NAP = 2*ALLPASS_COUNT;
	localparam int CM_DEPTH = NCOMB*COMB_LINE_DEPTH;
	localparam int AP_DEPTH = NAP*ALLPASS_LINE_DEPTH;
	localparam int CA_W = $clog2(CM_DEPTH);
	localparam int AA_W = $clog2(AP_DEPTH);
	localparam int CP_W = $clog2(COMB_LINE_DEPTH);
	localparam int AP_W = $clog2(ALLPASS_LINE_DEPTH);
	localparam int KC_W = $clog2(NCOMB);
	localparam int KA_W = $clog2(NAP);
	localparam int MAXC = (COMB_COUNT > ALLPASS_COUNT) ? COMB_COUNT : ALLPASS_COUNT;
	localparam int IDX_W = $clog2(MAXC+1);
	localparam int CLR_LEN = (CM_DEPTH > AP_DEPTH) ? CM_DEPTH : AP_DEPTH;
	localparam int CLR_W = $clog2(CLR_LEN+1);
	localparam int RW = srv_pkg::RND_W;

	// Fixed line lengths, worked out at elaboration.
	logic [CP_W:0] comb_len [NCOMB];
	logic [AP_W:0] ap_len [NAP];

	for (genvar g = 0; g < NCOMB; g++) begin : g_clen
		assign comb_len[g] = (CP_W+1)'(srv_pkg::line_len(
			srv_pkg::COMB_TUNE[g % COMB_COUNT]
			+ ((g >= COMB_COUNT) ? srv_pkg::STEREO_SPREAD : 0),
			AUDIO_RATE, COMB_LINE_DEPTH));
	end
	for (genvar g = 0; g < NAP; g++) begin : g_alen
		assign ap_len[g] = (AP_W+1)'(srv_pkg::line_len(
			srv_pkg::AP_TUNE[g % ALLPASS_COUNT]
			+ ((g >= ALLPASS_COUNT) ? srv_pkg::STEREO_SPREAD : 0),
			AUDIO_RATE, ALLPASS_LINE_DEPTH));
	end

	srv_pkg::state_t st_q, st_nxt;

	logic [CLR_W-1:0]              clr_cnt_q;
	logic [16:0]                   wet_mix_q;
	logic [16:0]                   mix_eff;
	logic signed [SAMPLE_WIDTH-1:0] in_l_q, in_r_q;
	logic signed [SAMPLE_WIDTH-1:0] res_l_q, res_r_q;
	logic signed [31:0]            feed_q, out_q, b_q, v_q;
	logic signed [35:0]            sum_q;
	logic                          ch_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CP_W-1:0]               comb_pos_q [NCOMB];
	logic [AP_W-1:0]               ap_pos_q [NAP];
	logic signed [31:0]            damp_q [NCOMB];
	logic                          m_tvalid_q;
	logic [DATA_W-1:0]             m_tdata_q;

	logic [KC_W-1:0] kc;
	logic [KA_W-1:0] ka;
	logic [CA_W-1:0] c_addr;
	logic [AA_W-1:0] a_addr;
	logic [CP_W:0]   c_pos_inc;
	logic [AP_W:0]   a_pos_inc;
	logic [CP_W-1:0] c_pos_nxt;
	logic [AP_W-1:0] a_pos_nxt;

	srv_pkg::mac_ctl_t                mac_ctl;
	logic signed [srv_pkg::OPA_W-1:0] mac_a;
	logic signed [srv_pkg::OPB_W-1:0] mac_b;
	logic signed [RW-1:0]             mac_rnd;

	logic            cm_we, ap_we;
	logic [CA_W-1:0] cm_waddr;
	logic [AA_W-1:0] ap_waddr;
	logic [31:0]     cm_wdata, ap_wdata, cm_rdata, ap_rdata;

	logic signed [31:0]             rnd_sat, comb_wr, ap_wr, ap_out, sum_sat;
	logic signed [SAMPLE_WIDTH-1:0] mix_sat, dry;
	logic                           s_fire, cfg_wr, out_free;

	assign s_fire = s_tvalid && s_tready;
	assign s_tready = (st_q == srv_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == srv_pkg::REG_WET_MIX);
	assign prdata = (paddr == srv_pkg::REG_WET_MIX) ? {15'd0, wet_mix_q} : 32'd0;
	assign mix_eff = (wet_mix_q > srv_pkg::MIX_FULL) ? srv_pkg::MIX_FULL : wet_mix_q;

	// Line selection: left lines first, then right lines.
	assign kc = ch_q ? KC_W'(COMB_COUNT + 32'(idx_q)) : KC_W'(idx_q);
	assign ka = ch_q ? KA_W'(ALLPASS_COUNT + 32'(idx_q)) : KA_W'(idx_q);
	assign c_addr = CA_W'(kc) * CA_W'(COMB_LINE_DEPTH) + CA_W'(comb_pos_q[kc]);
	assign a_addr = AA_W'(ka) * AA_W'(ALLPASS_LINE_DEPTH) + AA_W'(ap_pos_q[ka]);
	assign c_pos_inc = {1'b0, comb_pos_q[kc]} + (CP_W+1)'(1);
	assign a_pos_inc = {1'b0, ap_pos_q[ka]} + (AP_W+1)'(1);
	assign c_pos_nxt = (c_pos_inc == comb_len[kc]) ? '0 : c_pos_inc[CP_W-1:0];
	assign a_pos_nxt = (a_pos_inc == ap_len[ka]) ? '0 : a_pos_inc[AP_W-1:0];

	// Saturation of the rounded accumulator, the values written back to the lines, the allpass output and the comb sum.
	assign rnd_sat = srv_pkg::sat32(40'(mac_rnd));
	assign comb_wr = srv_pkg::sat32(40'(feed_q) + 40'(mac_rnd));
	assign ap_wr = srv_pkg::sat32(40'(v_q) + 40'(mac_rnd));
	assign ap_out = srv_pkg::sat32(40'(b_q) - 40'(v_q));
	assign sum_sat = srv_pkg::sat32(40'(sum_q) + 40'(out_q));
	assign dry = ch_q ? in_r_q : in_l_q;

	always_comb begin
		if (mac_rnd > RW'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 64'sd1)) begin
			mix_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end else if (mac_rnd < -RW'(64'sd1 <<< (SAMPLE_WIDTH-1))) begin
			mix_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			mix_sat = mac_rnd[SAMPLE_WIDTH-1:0];
		end
	end

	srv_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.rnd (mac_rnd)
	);

	srv_ram #(.DEPTH(CM_DEPTH), .WIDTH(32)) u_comb_ram (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.raddr (c_addr),
		.rdata (cm_rdata)
	);

	srv_ram #(.DEPTH(AP_DEPTH), .WIDTH(32)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (ap_waddr),
		.wdata (ap_wdata),
		.raddr (a_addr),
		.rdata (ap_rdata)
	);

	// Next state.
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			srv_pkg::ST_CLEAR: begin
				if (clr_cnt_q == CLR_W'(CLR_LEN-1)) st_nxt = srv_pkg::ST_IDLE;
			end
			srv_pkg::ST_IDLE: begin
				if (s_fire) begin
					st_nxt = (mix_eff <= srv_pkg::MIX_BYPASS) ? srv_pkg::ST_DONE
						: srv_pkg::ST_FEED;
				end
			end
			srv_pkg::ST_FEED:  st_nxt = srv_pkg::ST_FEED2;
			srv_pkg::ST_FEED2: st_nxt = srv_pkg::ST_C_RD;
			srv_pkg::ST_C_RD:  st_nxt = srv_pkg::ST_C_M1;
			srv_pkg::ST_C_M1:  st_nxt = srv_pkg::ST_C_M2;
			srv_pkg::ST_C_M2:  st_nxt = srv_pkg::ST_C_F;
			srv_pkg::ST_C_F:   st_nxt = srv_pkg::ST_C_M3;
			srv_pkg::ST_C_M3:  st_nxt = srv_pkg::ST_C_W;
			srv_pkg::ST_C_W: begin
				st_nxt = (idx_q == IDX_W'(COMB_COUNT-1)) ? srv_pkg::ST_A_RD
					: srv_pkg::ST_C_RD;
			end
			srv_pkg::ST_A_RD:  st_nxt = srv_pkg::ST_A_M;
			srv_pkg::ST_A_M:   st_nxt = srv_pkg::ST_A_W;
			srv_pkg::ST_A_W: begin
				st_nxt = (idx_q == IDX_W'(ALLPASS_COUNT-1)) ? srv_pkg::ST_WET
					: srv_pkg::ST_A_RD;
			end
			srv_pkg::ST_WET:   st_nxt = srv_pkg::ST_WET2;
			srv_pkg::ST_WET2:  st_nxt = srv_pkg::ST_MIX1;
			srv_pkg::ST_MIX1:  st_nxt = srv_pkg::ST_MIX2;
			srv_pkg::ST_MIX2:  st_nxt = srv_pkg::ST_MIX3;
			srv_pkg::ST_MIX3: begin
				st_nxt = ch_q ? srv_pkg::ST_DONE : srv_pkg::ST_C_RD;
			end
			srv_pkg::ST_DONE: begin
				if (out_free) st_nxt = srv_pkg::ST_IDLE;
			end
			default: st_nxt = srv_pkg::ST_CLEAR;
		endcase
	end

	// Unit and memory controls.
	always_comb begin
		mac_ctl = '{en: 1'b0, clr: 1'b0};
		mac_a = '0;
		mac_b = '0;
		cm_we = 1'b0;
		ap_we = 1'b0;
		cm_waddr = c_addr;
		ap_waddr = a_addr;
		cm_wdata = comb_wr;
		ap_wdata = ap_wr;
		unique case (st_q)
			srv_pkg::ST_CLEAR: begin
				cm_we = (32'(clr_cnt_q) < CM_DEPTH);
				ap_we = (32'(clr_cnt_q) < AP_DEPTH);
				cm_waddr = CA_W'(clr_cnt_q);
				ap_waddr = AA_W'(clr_cnt_q);
				cm_wdata = '0;
				ap_wdata = '0;
			end
			srv_pkg::ST_FEED: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'(in_l_q) + srv_pkg::OPA_W'(in_r_q);
				mac_b = srv_pkg::Q_FEED;
			end
			srv_pkg::ST_C_M1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'($signed(cm_rdata));
				mac_b = srv_pkg::Q_UNDAMP;
			end
			srv_pkg::ST_C_M2: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a = srv_pkg::OPA_W'(damp_q[kc]);
				mac_b = srv_pkg::Q_DAMP;
			end
			srv_pkg::ST_C_M3: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'(damp_q[kc]);
				mac_b = srv_pkg::Q_ROOM;
			end
			srv_pkg::ST_C_W: cm_we = 1'b1;
			srv_pkg::ST_A_M: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'($signed(ap_rdata));
				mac_b = srv_pkg::Q_APFB;
			end
			srv_pkg::ST_A_W: ap_we = 1'b1;
			srv_pkg::ST_WET: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'(v_q);
				mac_b = srv_pkg::Q_WET;
			end
			srv_pkg::ST_MIX1: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1};
				mac_a = srv_pkg::OPA_W'(dry);
				mac_b = $signed({1'b0, srv_pkg::MIX_FULL - mix_eff});
			end
			srv_pkg::ST_MIX2: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a = srv_pkg::OPA_W'(v_q);
				mac_b = $signed({1'b0, mix_eff});
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= srv_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
			wet_mix_q <= '0;
			m_tvalid_q <= 1'b0;
			ch_q <= 1'b0;
			idx_q <= '0;
			for (int i = 0; i < NCOMB; i++) begin
				comb_pos_q[i] <= '0;
				damp_q[i] <= '0;
			end
			for (int i = 0; i < NAP; i++) begin
				ap_pos_q[i] <= '0;
			end
		end else begin
			st_q <= st_nxt;
			if (cfg_wr) wet_mix_q <= pwdata[16:0];
			if (st_q == srv_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			// A finished word loads the result register once it is free.
			if (st_q == srv_pkg::ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (st_q)
				srv_pkg::ST_FEED2: begin
					ch_q <= 1'b0;
					idx_q <= '0;
				end
				srv_pkg::ST_C_F: damp_q[kc] <= rnd_sat;
				srv_pkg::ST_C_W: begin
					comb_pos_q[kc] <= c_pos_nxt;
					idx_q <= (idx_q == IDX_W'(COMB_COUNT-1)) ? '0 : idx_q + IDX_W'(1);
				end
				srv_pkg::ST_A_W: begin
					ap_pos_q[ka] <= a_pos_nxt;
					idx_q <= (idx_q == IDX_W'(ALLPASS_COUNT-1)) ? '0 : idx_q + IDX_W'(1);
				end
				srv_pkg::ST_MIX3: begin
					ch_q <= 1'b1;
					idx_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			in_l_q <= s_tdata[SAMPLE_WIDTH-1:0];
			in_r_q <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
			res_l_q <= s_tdata[SAMPLE_WIDTH-1:0];
			res_r_q <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
		end
		case (st_q)
			srv_pkg::ST_FEED2: begin
				feed_q <= rnd_sat;
				sum_q <= '0;
			end
			srv_pkg::ST_C_M1: out_q <= cm_rdata;
			srv_pkg::ST_C_W: begin
				sum_q <= sum_q + 36'(out_q);
				// The last comb of a channel seeds the allpass chain.
				v_q <= sum_sat;
			end
			srv_pkg::ST_A_M: b_q <= ap_rdata;
			srv_pkg::ST_A_W: v_q <= ap_out;
			srv_pkg::ST_WET2: v_q <= rnd_sat;
			srv_pkg::ST_MIX3: begin
				if (ch_q) res_r_q <= mix_sat;
				else res_l_q <= mix_sat;
				sum_q <= '0;
			end
			default: begin
			end
		endcase
		if (st_q == srv_pkg::ST_DONE && out_free) begin
			m_tdata_q <= DATA_W'({res_r_q, res_l_q});
		end
	end

endmodule
